// File: rtl/core/i2cdw_pkg.sv
// ----------------------------------------------------------------------------
// i2cdw_pkg
// Types and constants shared by the display write master and its sub-blocks.
// ----------------------------------------------------------------------------
package i2cdw_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEVICE_ADDRESS  = 3'd0,
		CFG_DATA_CONTROL    = 3'd1,
		CFG_COMMAND_CONTROL = 3'd2,
		CFG_HALF_BIT_TICKS  = 3'd3,
		CFG_ACK_TIMEOUT     = 3'd4
	} cfg_idx_t;

	localparam logic [7:0]  RST_DEVICE_ADDRESS  = 8'd120;
	localparam logic [7:0]  RST_DATA_CONTROL    = 8'd64;
	localparam logic [7:0]  RST_COMMAND_CONTROL = 8'd0;
	localparam logic [15:0] RST_HALF_BIT_TICKS  = 16'd4;
	localparam logic [7:0]  RST_ACK_TIMEOUT     = 8'd250;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_START = 4'd1,
		PH_BITLO = 4'd2,
		PH_BITHI = 4'd3,
		PH_ACKLO = 4'd4,
		PH_ACKHI = 4'd5,
		PH_LOAD  = 4'd6,
		PH_STOPA = 4'd7,
		PH_STOPB = 4'd8,
		PH_STOPC = 4'd9
	} phase_t;

	typedef enum logic [1:0] {
		KIND_ADDR = 2'd0,
		KIND_CTRL = 2'd1,
		KIND_DATA = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]  device_address;
		logic [7:0]  data_control;
		logic [7:0]  command_control;
		logic [15:0] half_bit_ticks;
		logic [7:0]  ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic       send_valid;
		logic [7:0] data_byte;
		logic       is_data;
		logic       last_byte;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic scl_out;
		logic sda_out;
		logic byte_taken;
		logic busy_res;
		logic ack_error;
	} result_t;

endpackage

// File: rtl/core/i2cdw_cfg.sv
// ----------------------------------------------------------------------------
// i2cdw_cfg
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module i2cdw_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [i2cdw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [i2cdw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output i2cdw_pkg::cfg_t                      cfg
);
	import i2cdw_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address  <= RST_DEVICE_ADDRESS;
			cfg_q.data_control    <= RST_DATA_CONTROL;
			cfg_q.command_control <= RST_COMMAND_CONTROL;
			cfg_q.half_bit_ticks  <= RST_HALF_BIT_TICKS;
			cfg_q.ack_timeout     <= RST_ACK_TIMEOUT;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEVICE_ADDRESS:  cfg_q.device_address  <= cfg_wdata[7:0];
				CFG_DATA_CONTROL:    cfg_q.data_control    <= cfg_wdata[7:0];
				CFG_COMMAND_CONTROL: cfg_q.command_control <= cfg_wdata[7:0];
				CFG_HALF_BIT_TICKS:  cfg_q.half_bit_ticks  <= cfg_wdata;
				CFG_ACK_TIMEOUT:     cfg_q.ack_timeout     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/i2cdw_engine.sv
// ----------------------------------------------------------------------------
// i2cdw_engine
// Bus sequencer: frame state and one step of start, bits, acknowledge and stop
// per request.
// ----------------------------------------------------------------------------
module i2cdw_engine #(
	parameter int TICK_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  i2cdw_pkg::item_t     item,
	input  i2cdw_pkg::cfg_t      cfg,
	output i2cdw_pkg::result_t   result
);
	import i2cdw_pkg::*;

	localparam int LW = ((TICK_BITS > 16) ? TICK_BITS : 16) + 1;

	phase_t               phase_q, phase_d;
	kind_t                kind_q, kind_d;
	logic [3:0]           bit_count_q, bit_count_d;
	logic [7:0]           shift_q, shift_d;
	logic [TICK_BITS-1:0] tick_q, tick_d;
	logic [7:0]           wait_q, wait_d;
	logic                 frame_is_data_q, frame_is_data_d;
	logic                 last_pending_q, last_pending_d;
	logic                 dropping_q, dropping_d;

	logic [TICK_BITS:0]   tick_plus;
	logic [LW-1:0]        limit_raw;
	logic [LW-1:0]        limit_cap;
	logic [LW-1:0]        limit;
	logic                 seg_done;
	logic [TICK_BITS-1:0] tick_step;
	logic [3:0]           bit_count_inc;
	logic                 ack_fail;
	logic                 data_last;

	assign tick_plus = {1'b0, tick_q} + {{TICK_BITS{1'b0}}, 1'b1};
	assign limit_raw = (cfg.half_bit_ticks == 16'd0) ? LW'(1) : LW'(cfg.half_bit_ticks);
	assign limit_cap = LW'(1) << TICK_BITS;
	assign limit     = (limit_raw > limit_cap) ? limit_cap : limit_raw;
	assign seg_done  = (LW'(tick_plus) >= limit);
	assign tick_step = seg_done ? '0 : tick_plus[TICK_BITS-1:0];

	assign bit_count_inc = bit_count_q + 4'd1;
	assign ack_fail      = item.sda_in && (wait_q >= cfg.ack_timeout);
	assign data_last     = (kind_q == KIND_DATA) && last_pending_q;

	always_comb begin
		phase_d         = phase_q;
		kind_d          = kind_q;
		bit_count_d     = bit_count_q;
		shift_d         = shift_q;
		tick_d          = tick_q;
		wait_d          = wait_q;
		frame_is_data_d = frame_is_data_q;
		last_pending_d  = last_pending_q;
		dropping_d      = dropping_q;
		case (phase_q)
			PH_START: begin
				tick_d = tick_step;
				if (seg_done) begin
					shift_d     = cfg.device_address;
					kind_d      = KIND_ADDR;
					bit_count_d = '0;
					tick_d      = '0;
					phase_d     = PH_BITLO;
				end
			end
			PH_BITLO: begin
				tick_d = tick_step;
				if (seg_done) begin
					phase_d = PH_BITHI;
				end
			end
			PH_BITHI: begin
				tick_d = tick_step;
				if (seg_done) begin
					shift_d     = {shift_q[6:0], 1'b0};
					bit_count_d = bit_count_inc;
					phase_d     = (bit_count_inc >= BITS_PER_BYTE) ? PH_ACKLO : PH_BITLO;
				end
			end
			PH_ACKLO: begin
				tick_d = tick_step;
				if (seg_done) begin
					wait_d  = '0;
					phase_d = PH_ACKHI;
				end
			end
			PH_ACKHI: begin
				tick_d = '0;
				if (!item.sda_in) begin
					wait_d = '0;
					if (kind_q == KIND_ADDR) begin
						shift_d     = frame_is_data_q ? cfg.data_control : cfg.command_control;
						kind_d      = KIND_CTRL;
						bit_count_d = '0;
						phase_d     = PH_BITLO;
					end else if (data_last) begin
						phase_d = PH_STOPA;
					end else begin
						phase_d = PH_LOAD;
					end
				end else if (ack_fail) begin
					dropping_d = !data_last;
					wait_d     = '0;
					phase_d    = PH_STOPA;
				end else begin
					wait_d = wait_q + 8'd1;
				end
			end
			PH_LOAD: begin
				if (item.send_valid) begin
					last_pending_d = item.last_byte;
					shift_d        = item.data_byte;
					kind_d         = KIND_DATA;
					bit_count_d    = '0;
					tick_d         = '0;
					phase_d        = PH_BITLO;
				end
			end
			PH_STOPA: begin
				tick_d = tick_step;
				if (seg_done) begin
					phase_d = PH_STOPB;
				end
			end
			PH_STOPB: begin
				tick_d = tick_step;
				if (seg_done) begin
					phase_d = PH_STOPC;
				end
			end
			PH_STOPC: begin
				tick_d = tick_step;
				if (seg_done) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				if (item.send_valid) begin
					if (dropping_q) begin
						if (item.last_byte) begin
							dropping_d = 1'b0;
						end
					end else begin
						frame_is_data_d = item.is_data;
						last_pending_d  = 1'b0;
						tick_d          = '0;
						phase_d         = PH_START;
					end
				end
			end
		endcase
	end

	always_comb begin
		result            = '0;
		result.scl_out    = 1'b1;
		result.sda_out    = 1'b1;
		result.busy_res   = (phase_q != PH_IDLE) || dropping_q;
		case (phase_q)
			PH_START: begin
				result.sda_out = 1'b0;
			end
			PH_BITLO: begin
				result.scl_out = 1'b0;
				result.sda_out = shift_q[7];
			end
			PH_BITHI: begin
				result.sda_out = shift_q[7];
			end
			PH_ACKLO: begin
				result.scl_out = 1'b0;
			end
			PH_ACKHI: begin
				result.ack_error = ack_fail;
			end
			PH_LOAD: begin
				result.scl_out    = 1'b0;
				result.byte_taken = item.send_valid;
			end
			PH_STOPA: begin
				result.scl_out = 1'b0;
				result.sda_out = 1'b0;
			end
			PH_STOPB: begin
				result.sda_out = 1'b0;
			end
			PH_STOPC: begin
			end
			default: begin
				result.byte_taken = item.send_valid && dropping_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			kind_q          <= KIND_ADDR;
			bit_count_q     <= '0;
			shift_q         <= '0;
			tick_q          <= '0;
			wait_q          <= '0;
			frame_is_data_q <= 1'b0;
			last_pending_q  <= 1'b0;
			dropping_q      <= 1'b0;
		end else if (fire) begin
			phase_q         <= phase_d;
			kind_q          <= kind_d;
			bit_count_q     <= bit_count_d;
			shift_q         <= shift_d;
			tick_q          <= tick_d;
			wait_q          <= wait_d;
			frame_is_data_q <= frame_is_data_d;
			last_pending_q  <= last_pending_d;
			dropping_q      <= dropping_d;
		end
	end

endmodule

// File: rtl/core/i2c_display_write_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_display_write_master_unit
// Tick-driven, write-only I2C master that frames bytes for a display controller.
// ----------------------------------------------------------------------------
// Each input request is one bus tick: the offered payload byte with its flags
// and the sampled SDA level. Each request yields exactly one output request
// carrying the SCL and SDA levels for that tick, whether the offered byte was
// taken, the busy flag and the acknowledge error pulse.
// Requests pass an input register and then a result register. One request is
// accepted in every cycle while the output side keeps up. The bus sequencer
// updates its state once per request, in the cycle the request leaves the
// input register. When the receiver stalls, the result register holds its
// request and the input register fills; a further request is then stalled
// until the result is taken. Reset empties both registers, returns the
// sequencer to idle and loads the configuration registers with their default
// values. Configuration writes take effect at the next clock edge. The user is
// to make them only while the block is idle; the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module i2c_display_write_master_unit #(
	parameter int TICK_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [i2cdw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [i2cdw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 send_valid,
	input  logic [7:0]                           data_byte,
	input  logic                                 is_data,
	input  logic                                 last_byte,
	input  logic                                 sda_in,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 scl_out,
	output logic                                 sda_out,
	output logic                                 byte_taken,
	output logic                                 busy_res,
	output logic                                 ack_error
);
	import i2cdw_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_c;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;
	logic    fire;

	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	i2cdw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	i2cdw_engine #(
		.TICK_BITS (TICK_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.send_valid <= send_valid;
			item_s1.data_byte  <= data_byte;
			item_s1.is_data    <= is_data;
			item_s1.last_byte  <= last_byte;
			item_s1.sda_in     <= sda_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result_c;
		end
	end

	assign out_valid  = valid_s2;
	assign scl_out    = result_s2.scl_out;
	assign sda_out    = result_s2.sda_out;
	assign byte_taken = result_s2.byte_taken;
	assign busy_res   = result_s2.busy_res;
	assign ack_error  = result_s2.ack_error;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("Input stalled while the result register could advance.");

	a_error_on_released_bus: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ack_error) |-> (busy_res && scl_out && sda_out))
		else $error("Acknowledge error outside the acknowledge high phase.");

	a_error_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(byte_taken && ack_error))
		else $error("Byte taken in the same tick as an acknowledge error.");

endmodule

// File: tb/i2c_display_write_master_unit_tb.sv
// ----------------------------------------------------------------------------
// i2c_display_write_master_unit_tb
// Self-checking bench for the tick-driven I2C display write master.
// ----------------------------------------------------------------------------
// Every request is one bus tick. A bus-level predictor inside the bench runs
// the same tick and queues the levels, taken flag, busy flag and error pulse
// it expects. A short table opens the run: a frame start, the address bits,
// a missing acknowledge under a zero timeout, the stop and the discarding of
// the dropped bytes. Random traffic follows under several register settings.
// Most of it comes from a caller and a slave that reacts to the bus phase, and
// the rest is noise. The receiver holds off for a long stretch once, and the
// sender lets the results drain before every register update but the first.
// ----------------------------------------------------------------------------
module i2c_display_write_master_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cdw_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYC    = 60;
	localparam int TAIL_CYC    = 8;

	typedef struct packed {
		item_t   req;
		logic    chk;
		result_t want;
	} dir_row_t;

	// Columns: valid, byte, is_data, last, sda_in, typed check, then the
	// expected scl, sda, taken, busy and error bits.
	localparam int DIR_N = 26;
	localparam dir_row_t DIR_TAB [DIR_N] = '{
		{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 5'b11000},
		{1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 5'b11000},
		{1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 5'b10010},
		{1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
		{1'b1, 8'h55, 1'b1, 1'b0, 1'b1, 1'b0, 5'b00000},
		{1'b0, 8'hAA, 1'b0, 1'b1, 1'b0, 1'b0, 5'b00000},
		{1'b1, 8'h01, 1'b1, 1'b1, 1'b1, 1'b0, 5'b00000},
		{1'b0, 8'h80, 1'b0, 1'b0, 1'b1, 1'b0, 5'b00000},
		{1'b1, 8'h7F, 1'b1, 1'b0, 1'b0, 1'b0, 5'b00000},
		{1'b0, 8'hFE, 1'b0, 1'b1, 1'b1, 1'b0, 5'b00000},
		{1'b1, 8'h0F, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
		{1'b1, 8'hF0, 1'b1, 1'b1, 1'b0, 1'b0, 5'b00000},
		{1'b0, 8'h33, 1'b1, 1'b0, 1'b1, 1'b0, 5'b00000},
		{1'b1, 8'hCC, 1'b0, 1'b1, 1'b1, 1'b0, 5'b00000},
		{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 5'b00000},
		{1'b1, 8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 5'b00000},
		{1'b1, 8'h5A, 1'b1, 1'b0, 1'b0, 1'b0, 5'b00000},
		{1'b0, 8'hA5, 1'b0, 1'b1, 1'b1, 1'b0, 5'b00000},
		{1'b1, 8'h3C, 1'b1, 1'b1, 1'b1, 1'b0, 5'b00000},
		{1'b1, 8'hC3, 1'b0, 1'b0, 1'b0, 1'b0, 5'b00000},
		{1'b0, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 5'b11011},
		{1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 5'b00000},
		{1'b0, 8'h12, 1'b0, 1'b0, 1'b1, 1'b0, 5'b00000},
		{1'b1, 8'h34, 1'b1, 1'b0, 1'b0, 1'b0, 5'b00000},
		{1'b1, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 5'b11110},
		{1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 5'b11110}
	};

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_wr_en  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic                  send_valid = 1'b0;
	logic [7:0]            data_byte  = '0;
	logic                  is_data    = 1'b0;
	logic                  last_byte  = 1'b0;
	logic                  sda_in     = 1'b1;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic                  scl_out;
	logic                  sda_out;
	logic                  byte_taken;
	logic                  busy_res;
	logic                  ack_error;

	i2c_display_write_master_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.send_valid (send_valid),
		.data_byte  (data_byte),
		.is_data    (is_data),
		.last_byte  (last_byte),
		.sda_in     (sda_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl_out    (scl_out),
		.sda_out    (sda_out),
		.byte_taken (byte_taken),
		.busy_res   (busy_res),
		.ack_error  (ack_error)
	);

	always #10 clk = ~clk;

	// Predictor state and register mirror.
	cfg_t        cfg_m = '{device_address: RST_DEVICE_ADDRESS,
	                       data_control: RST_DATA_CONTROL,
	                       command_control: RST_COMMAND_CONTROL,
	                       half_bit_ticks: RST_HALF_BIT_TICKS,
	                       ack_timeout: RST_ACK_TIMEOUT};
	phase_t      bus_ph     = PH_IDLE;
	logic [3:0]  bits_sent  = '0;
	logic [7:0]  shift_reg  = '0;
	logic [15:0] seg_ticks  = '0;
	logic [7:0]  ack_waits  = '0;
	logic        frame_data = 1'b0;
	logic        last_armed = 1'b0;
	logic        dropping   = 1'b0;
	kind_t       byte_kind  = KIND_ADDR;
	logic        nack_hold  = 1'b0;

	result_t tick_out_q [$];

	int n_reqs = 0, n_results = 0, n_bad = 0;
	int n_frames = 0, n_taken = 0, n_timeouts = 0;
	int tx_idle_pct = 16;
	int rx_idle_pct = 72;
	int hold_asks = 0, hold_seen = 0, hold_left = 0;
	int cycles = 0;

	function automatic bit seg_end();
		int lim;
		lim = (cfg_m.half_bit_ticks == 0) ? 1 : int'(cfg_m.half_bit_ticks);
		if (int'(seg_ticks) + 1 >= lim) begin
			seg_ticks = '0;
			return 1'b1;
		end
		seg_ticks = seg_ticks + 1'b1;
		return 1'b0;
	endfunction

	function automatic void load_byte(input logic [7:0] value, input kind_t kind);
		shift_reg = value;
		byte_kind = kind;
		bits_sent = '0;
		seg_ticks = '0;
		bus_ph    = PH_BITLO;
	endfunction

	function automatic result_t bus_tick(input item_t req);
		result_t r;
		r          = '0;
		r.scl_out  = 1'b1;
		r.sda_out  = 1'b1;
		r.busy_res = (bus_ph != PH_IDLE) || dropping;
		case (bus_ph)
		PH_START: begin
			r.sda_out = 1'b0;
			if (seg_end())
				load_byte(cfg_m.device_address, KIND_ADDR);
		end
		PH_BITLO: begin
			r.scl_out = 1'b0;
			r.sda_out = shift_reg[7];
			if (seg_end())
				bus_ph = PH_BITHI;
		end
		PH_BITHI: begin
			r.sda_out = shift_reg[7];
			if (seg_end()) begin
				shift_reg = shift_reg << 1;
				bits_sent = bits_sent + 1'b1;
				if (bits_sent >= BITS_PER_BYTE)
					bus_ph = PH_ACKLO;
				else
					bus_ph = PH_BITLO;
			end
		end
		PH_ACKLO: begin
			r.scl_out = 1'b0;
			if (seg_end()) begin
				ack_waits = '0;
				bus_ph    = PH_ACKHI;
			end
		end
		PH_ACKHI: begin
			seg_ticks = '0;
			if (!req.sda_in) begin
				ack_waits = '0;
				if (byte_kind == KIND_ADDR)
					load_byte(frame_data ? cfg_m.data_control : cfg_m.command_control,
						KIND_CTRL);
				else if (byte_kind == KIND_DATA && last_armed)
					bus_ph = PH_STOPA;
				else
					bus_ph = PH_LOAD;
			end else if (ack_waits >= cfg_m.ack_timeout) begin
				r.ack_error = 1'b1;
				dropping    = !(byte_kind == KIND_DATA && last_armed);
				ack_waits   = '0;
				bus_ph      = PH_STOPA;
				n_timeouts++;
			end else begin
				ack_waits = ack_waits + 1'b1;
			end
		end
		PH_LOAD: begin
			r.scl_out = 1'b0;
			if (req.send_valid) begin
				r.byte_taken = 1'b1;
				last_armed   = req.last_byte;
				load_byte(req.data_byte, KIND_DATA);
			end
		end
		PH_STOPA: begin
			r.scl_out = 1'b0;
			r.sda_out = 1'b0;
			if (seg_end())
				bus_ph = PH_STOPB;
		end
		PH_STOPB: begin
			r.sda_out = 1'b0;
			if (seg_end())
				bus_ph = PH_STOPC;
		end
		PH_STOPC: begin
			if (seg_end())
				bus_ph = PH_IDLE;
		end
		default: begin
			bus_ph = PH_IDLE;
			if (req.send_valid) begin
				if (dropping) begin
					r.byte_taken = 1'b1;
					if (req.last_byte)
						dropping = 1'b0;
				end else begin
					frame_data = req.is_data;
					last_armed = 1'b0;
					seg_ticks  = '0;
					bus_ph     = PH_START;
					n_frames++;
				end
			end
		end
		endcase
		if (r.byte_taken)
			n_taken++;
		return r;
	endfunction

	// A caller that keeps offering bytes and a slave that mostly acknowledges,
	// with now and then a long refusal; a tenth of the requests are noise.
	function automatic item_t make_req(input bit noise);
		item_t req;
		req.data_byte = 8'($urandom_range(255));
		req.is_data   = 1'($urandom_range(1));
		if (noise) begin
			req.send_valid = 1'($urandom_range(1));
			req.last_byte  = 1'($urandom_range(1));
			req.sda_in     = 1'($urandom_range(1));
			return req;
		end
		req.send_valid = ($urandom_range(9) != 0);
		req.last_byte  = ($urandom_range(3) == 0);
		if (bus_ph == PH_ACKHI) begin
			if (ack_waits == 0)
				nack_hold = ($urandom_range(15) == 0);
			req.sda_in = nack_hold ? 1'b1 : ($urandom_range(2) == 0);
		end else begin
			req.sda_in = 1'($urandom_range(1));
		end
		return req;
	endfunction

	task automatic offer(input item_t req, input logic typed, input result_t want);
		result_t got;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{send_valid, data_byte, is_data, last_byte, sda_in} <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = bus_tick(req);
		tick_out_q.push_back(typed ? want : got);
		n_reqs++;
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++)
			offer(make_req($urandom_range(9) == 0), 1'b0, '0);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (tick_out_q.size() != 0);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
		CFG_DEVICE_ADDRESS:  cfg_m.device_address  = value[7:0];
		CFG_DATA_CONTROL:    cfg_m.data_control    = value[7:0];
		CFG_COMMAND_CONTROL: cfg_m.command_control = value[7:0];
		CFG_HALF_BIT_TICKS:  cfg_m.half_bit_ticks  = value;
		CFG_ACK_TIMEOUT:     cfg_m.ack_timeout     = value[7:0];
		default: ;
		endcase
	endtask

	task automatic set_cfg(input logic [15:0] addr, input logic [15:0] dctl,
			input logic [15:0] cctl, input logic [15:0] half, input logic [15:0] tmo);
		write_reg(CFG_DEVICE_ADDRESS, addr);
		write_reg(CFG_DATA_CONTROL, dctl);
		write_reg(CFG_COMMAND_CONTROL, cctl);
		write_reg(CFG_HALF_BIT_TICKS, half);
		write_reg(CFG_ACK_TIMEOUT, tmo);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic note_bad(input string why, input result_t want, input result_t got);
		n_bad++;
		if (n_bad <= 10) begin
			$display("%0t: %s at result %0d", $realtime, why, n_results);
			$display("  expected scl=%b sda=%b taken=%b busy=%b err=%b",
				want.scl_out, want.sda_out, want.byte_taken, want.busy_res,
				want.ack_error);
			$display("  got      scl=%b sda=%b taken=%b busy=%b err=%b",
				got.scl_out, got.sda_out, got.byte_taken, got.busy_res,
				got.ack_error);
		end
	endtask

	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYC;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{scl_out, sda_out, byte_taken, busy_res, ack_error};
			if (tick_out_q.size() == 0) begin
				note_bad("unexpected result", '0, got);
			end else begin
				want = tick_out_q.pop_front();
				if (got !== want)
					note_bad("mismatch", want, got);
			end
			n_results++;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** i2c_display_write_master_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_cfg(16'(RST_DEVICE_ADDRESS), 16'(RST_DATA_CONTROL), 16'(RST_COMMAND_CONTROL),
			16'd1, 16'd0);
		for (int i = 0; i < DIR_N; i++)
			offer(DIR_TAB[i].req, DIR_TAB[i].chk, DIR_TAB[i].want);

		settle();
		set_cfg(16'h0000, 16'h00FF, 16'h0000, 16'd2, 16'd3);
		run_random(350);

		settle();
		tx_idle_pct = 72;
		rx_idle_pct <= 16;
		set_cfg(16'h00FF, 16'h0000, 16'h00FF, 16'd1, 16'd255);
		run_random(350);

		settle();
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		set_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'd0, 16'd1);
		run_random(100);
		hold_asks <= hold_asks + 1;
		run_random(250);

		settle();
		set_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'hFFFF,
			16'($urandom_range(255, 1)));
		run_random(20);

		settle();
		set_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(2, 1)),
			16'($urandom_range(8, 1)));
		run_random(380);

		settle();
		repeat (TAIL_CYC) @(posedge clk);
		if (tick_out_q.size() != 0)
			n_bad++;

		$display("Sent %0d bus ticks: %0d frames, %0d bytes taken, %0d ack timeouts.",
			n_reqs, n_frames, n_taken, n_timeouts);
		$display("Checked %0d results, %0d of them wrong or unexpected.", n_results, n_bad);
		if (n_bad == 0)
			$display("** i2c_display_write_master_unit: PASSED **");
		else
			$display("** i2c_display_write_master_unit: FAILED **");
		$finish;
	end

endmodule
